>>> sv/pdcc_pkg.sv
// ----------------------------------------------------------------------------
// pdcc_pkg
// Types and constants shared by the packet deframer with CRC-16 check.
// ----------------------------------------------------------------------------
package pdcc_pkg;

   localparam int unsigned STAMP_W     = 27;
   localparam int unsigned TOPIC_W     = 6;
   localparam int unsigned COMMAND_W   = 4;
   localparam int unsigned LENGTH_W    = 11;
   localparam int unsigned CRC_W       = 16;

   localparam int unsigned MAX_FRAME_BYTES_DEFAULT = 4095;

   // header is bytes 0..5, CRC is the last two bytes
   localparam int unsigned HDR_LEN = 6;
   localparam int unsigned MIN_FRAME_POS = 7;   // position of the last byte of a minimal frame
   localparam int unsigned PAYLOAD_POS   = 8;   // first position at which a payload byte leaves

   localparam logic [STAMP_W-1:0] DAY_LIMIT_RESET = 27'd86400000;

   localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

   // result queue; depth must be a power of two
   localparam int unsigned RQ_DEPTH = 4;

   typedef enum logic [2:0] {
      STATUS_OK         = 3'd0,
      STATUS_TOO_SHORT  = 3'd1,
      STATUS_CRC_ERR    = 3'd2,
      STATUS_LENGTH_ERR = 3'd3,
      STATUS_STAMP_OVF  = 3'd4
   } status_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_end;
   } req_item_type;

   typedef struct packed {
      logic                 frame_done;
      logic [7:0]           payload_byte;
      logic [2:0]           status;
      logic [STAMP_W-1:0]   millistamp;
      logic [TOPIC_W-1:0]   topic;
      logic [COMMAND_W-1:0] command;
      logic [LENGTH_W-1:0]  decl_length;
      logic [CRC_W-1:0]     trailer_crc;
   } rsp_item_type;

   // CRC-16/XMODEM, one byte, MSB first
   function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [7:0] data);
      logic [CRC_W-1:0] c;
      c = crc ^ {data, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[CRC_W-1]) begin
            c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[CRC_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

>>> sv/packet_deframe_crc_check.sv
// ----------------------------------------------------------------------------
// packet_deframe_crc_check
// Splits a decoded packet into header fields and payload bytes, checks the
// trailing CRC-16/XMODEM and reports a closing status item per packet.
// ----------------------------------------------------------------------------
//
//  channel | ports                         | direction | moves
//  --------+-------------------------------+-----------+---------------------
//  req     | req_valid req_stall req_item  | in        | one packet byte
//  rsp     | rsp_valid rsp_stall rsp_item  | out       | payload byte/summary
//  csr     | csr_wr_en csr_wr_data         | in        | day_limit write
//
//  One byte is taken per cycle while req_stall is low. CRC update, header
//  capture and checks are done in the accept cycle; results are registered in
//  a 4-entry result queue. A byte may produce two items (last payload byte and
//  summary), so req_stall rises while fewer than two queue entries are free.
//  Synchronous active-high reset clears counters, CRC, queue and sets day_limit
//  to 86400000. No clearing pass.
//
module packet_deframe_crc_check #(
   parameter int unsigned MAX_FRAME_BYTES = pdcc_pkg::MAX_FRAME_BYTES_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  pdcc_pkg::req_item_type           req_item,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output pdcc_pkg::rsp_item_type           rsp_item,
   input  logic                             csr_wr_en,
   input  logic [pdcc_pkg::STAMP_W-1:0]     csr_wr_data
);
   import pdcc_pkg::*;

   localparam int unsigned POS_W = $clog2(MAX_FRAME_BYTES + 1);
   localparam int unsigned PTR_W = $clog2(RQ_DEPTH);
   localparam int unsigned QCNT_W = $clog2(RQ_DEPTH + 1);
   localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_FRAME_BYTES);

   // configuration
   logic [STAMP_W-1:0] day_limit_ff;

   // frame state
   logic [POS_W-1:0]     byte_count_ff, byte_count_in;
   logic [CRC_W-1:0]     crc_ff, crc_in;
   logic [7:0]           held_older_ff, held_older_in;
   logic [7:0]           held_newer_ff, held_newer_in;
   logic [STAMP_W-1:0]   stamp_ff, stamp_in;
   logic [TOPIC_W-1:0]   topic_ff, topic_in;
   logic [COMMAND_W-1:0] command_ff, command_in;
   logic [LENGTH_W-1:0]  length_ff, length_in;

   // result queue
   rsp_item_type        rq_ff [RQ_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   qcount_ff, qcount_in;

   logic          accept, pop;
   logic [7:0]    rx_b;
   logic          last;
   logic [POS_W-1:0] pos;
   logic [CRC_W-1:0] crc_upd;
   logic [CRC_W-1:0] rx_crc;
   status_type    status;
   rsp_item_type  pay_item, sum_item, push_a_item;
   logic          emit_pay, push_a, push_b;
   logic [1:0]    push_n;

   assign accept    = req_valid && !req_stall;
   assign pop       = rsp_valid && !rsp_stall;
   assign req_stall = qcount_ff > QCNT_W'(RQ_DEPTH - 2);
   assign rsp_valid = qcount_ff != '0;
   assign rsp_item  = rq_ff[rd_ptr_ff];

   assign rx_b = req_item.rx_byte;
   assign last = req_item.frame_end;
   assign pos  = byte_count_ff;

   // CRC runs on the byte leaving the two-byte delay
   assign crc_upd = (pos >= POS_W'(2)) ? crc_byte(crc_ff, held_older_ff) : crc_ff;
   assign rx_crc  = {held_newer_ff, rx_b};

   // header capture
   always_comb begin
      stamp_in   = stamp_ff;
      topic_in   = topic_ff;
      command_in = command_ff;
      length_in  = length_ff;
      if (accept && pos < POS_W'(HDR_LEN)) begin
         unique case (pos[2:0])
            3'd0: begin
               stamp_in   = {rx_b, 19'd0};
               topic_in   = '0;
               command_in = '0;
               length_in  = '0;
            end
            3'd1: stamp_in[18:11] = rx_b;
            3'd2: stamp_in[10:3]  = rx_b;
            3'd3: begin
               stamp_in[2:0] = rx_b[7:5];
               topic_in      = {rx_b[4:0], 1'b0};
            end
            3'd4: begin
               topic_in[0]   = rx_b[7];
               command_in    = rx_b[6:3];
               length_in[10:8] = rx_b[2:0];
            end
            3'd5: length_in[7:0] = rx_b;
            default: ;
         endcase
      end
   end

   // frame counter, CRC and byte delay
   always_comb begin
      byte_count_in = byte_count_ff;
      crc_in        = crc_ff;
      held_older_in = held_older_ff;
      held_newer_in = held_newer_ff;
      if (accept) begin
         if (last) begin
            byte_count_in = '0;
            crc_in        = '0;
            held_older_in = '0;
            held_newer_in = '0;
         end else begin
            crc_in        = crc_upd;
            held_older_in = held_newer_ff;
            held_newer_in = rx_b;
            if (byte_count_ff < POS_MAX) begin
               byte_count_in = byte_count_ff + POS_W'(1);
            end
         end
      end
   end

   // closing status, first failing check wins
   always_comb begin
      if (pos < POS_W'(MIN_FRAME_POS)) begin
         status = STATUS_TOO_SHORT;
      end else if (rx_crc != crc_upd) begin
         status = STATUS_CRC_ERR;
      end else if ((pos - POS_W'(MIN_FRAME_POS)) != POS_W'(length_ff)) begin
         status = STATUS_LENGTH_ERR;
      end else if (stamp_ff >= day_limit_ff) begin
         status = STATUS_STAMP_OVF;
      end else begin
         status = STATUS_OK;
      end
   end

   always_comb begin
      pay_item              = '0;
      pay_item.payload_byte = held_older_ff;

      sum_item            = '0;
      sum_item.frame_done = 1'b1;
      sum_item.status     = status;
      // short frames report zero header fields
      if (status != STATUS_TOO_SHORT) begin
         sum_item.millistamp   = stamp_ff;
         sum_item.topic        = topic_ff;
         sum_item.command      = command_ff;
         sum_item.decl_length  = length_ff;
         sum_item.trailer_crc  = rx_crc;
      end
   end

   assign emit_pay    = pos >= POS_W'(PAYLOAD_POS);
   assign push_a      = accept && (emit_pay || last);
   assign push_b      = accept && emit_pay && last;
   assign push_a_item = emit_pay ? pay_item : sum_item;
   assign push_n      = {1'b0, push_a} + {1'b0, push_b};

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push_n);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      qcount_in = qcount_ff + QCNT_W'(push_n) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         day_limit_ff  <= DAY_LIMIT_RESET;
         byte_count_ff <= '0;
         crc_ff        <= '0;
         held_older_ff <= '0;
         held_newer_ff <= '0;
         stamp_ff      <= '0;
         topic_ff      <= '0;
         command_ff    <= '0;
         length_ff     <= '0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         qcount_ff     <= '0;
      end else begin
         if (csr_wr_en) begin
            day_limit_ff <= csr_wr_data;
         end
         byte_count_ff <= byte_count_in;
         crc_ff        <= crc_in;
         held_older_ff <= held_older_in;
         held_newer_ff <= held_newer_in;
         stamp_ff      <= stamp_in;
         topic_ff      <= topic_in;
         command_ff    <= command_in;
         length_ff     <= length_in;
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         qcount_ff     <= qcount_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push_a) begin
         rq_ff[wr_ptr_ff] <= push_a_item;
      end
      if (push_b) begin
         rq_ff[wr_ptr_ff + PTR_W'(1)] <= sum_item;
      end
   end

   // ------------------------------------------------------------------------
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      qcount_ff <= QCNT_W'(RQ_DEPTH))
      else $error("result queue overflow");

   a_room_for_two: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> qcount_ff <= QCNT_W'(RQ_DEPTH - 2))
      else $error("byte taken without room for two items");

   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      accept && last |=> byte_count_ff == '0 && crc_ff == '0)
      else $error("frame state not cleared after last byte");

   a_crc_idle_early: assert property (@(posedge clock) disable iff (reset)
      byte_count_ff < POS_W'(3) |-> crc_ff == '0)
      else $error("CRC moved before delay filled");

   a_summary_pairs: assert property (@(posedge clock) disable iff (reset)
      push_b |-> push_a && last)
      else $error("second item without summary");

endmodule
